@@ hdl/cbsm_pkg.sv @@
// Shared types and constants for the cartridge bank switch mapper.
// Holds the item structs, the configuration struct and the access codes.
// No dependencies.
package cbsm_pkg;

    // Access codes carried in the op field.
    localparam logic [1:0] OP_CPU_READ  = 2'd0;
    localparam logic [1:0] OP_CPU_WRITE = 2'd1;
    localparam logic [1:0] OP_PPU_READ  = 2'd2;
    localparam logic [1:0] OP_PPU_WRITE = 2'd3;

    // Result codes carried in the kind field.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_PRG  = 2'd2;
    localparam logic [1:0] KIND_CHR  = 2'd3;

    // Configuration register indexes (taken from paddr bit 2).
    localparam logic REG_PRG_BANKS = 1'b0;
    localparam logic REG_CHR_BANKS = 1'b1;

    // Configuration port sizes and reset values.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [5:0] PRG_BANKS_RST = 6'd32;
    localparam logic [8:0] CHR_BANKS_RST = 9'd256;
    // Middle program window after reset: prg_banks minus three, five bits.
    localparam logic [4:0] PRG_MID_RST = 5'(PRG_BANKS_RST - 6'd3);

    // CPU address regions, by the top nibble of the address.
    localparam logic [3:0] REGION_LATCH  = 4'h6;
    localparam logic [3:0] REGION_ID     = 4'h7;
    localparam logic [3:0] REGION_PRG_LO = 4'h8;
    localparam logic [3:0] REGION_MIRROR = 4'h9;
    localparam logic [3:0] REGION_PRG_MID = 4'hA;
    localparam logic [3:0] REGION_CHR_FIRST = 4'hB;
    localparam logic [3:0] REGION_CHR_LAST  = 4'hE;

    // Fixed read values of the register windows.
    localparam logic [7:0] LATCH_READ_BASE = 8'h60;
    localparam logic [7:0] ID_READ_VALUE   = 8'h70;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [17:0] mem_address;
        logic [7:0]  read_data;
        logic        mirror_horizontal;
    } out_item_t;

    typedef struct packed {
        logic [5:0] prg_banks;
        logic [8:0] chr_banks;
    } cfg_t;

endpackage

@@ hdl/cbsm_cfg.sv @@
// Configuration registers of the mapper behind an APB-style write port.
// Holds the program and character memory sizes.
// Depends on cbsm_pkg.
module cbsm_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbsm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cbsm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cbsm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output cbsm_pkg::cfg_t                     cfg
);

    logic       wr_en;
    logic       reg_sel;
    logic [5:0] prg_banks_reg;
    logic [8:0] chr_banks_reg;

    // Registers sit at byte addresses 0 and 4.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg <= cbsm_pkg::PRG_BANKS_RST;
            chr_banks_reg <= cbsm_pkg::CHR_BANKS_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == cbsm_pkg::REG_PRG_BANKS)
            begin
                prg_banks_reg <= pwdata[5:0];
            end
            else
            begin
                chr_banks_reg <= pwdata[8:0];
            end
        end
    end

    // Read back.
    always_comb
    begin
        if (reg_sel == cbsm_pkg::REG_PRG_BANKS)
        begin
            prdata = {{(cbsm_pkg::CFG_DATA_W-6){1'b0}}, prg_banks_reg};
        end
        else
        begin
            prdata = {{(cbsm_pkg::CFG_DATA_W-9){1'b0}}, chr_banks_reg};
        end
    end

    assign cfg.prg_banks = prg_banks_reg;
    assign cfg.chr_banks = chr_banks_reg;

endmodule

@@ hdl/cbsm_xlate.sv @@
// Bank state and address translation of the mapper.
// Decodes one bus access, updates the bank registers and forms the result.
// Depends on cbsm_pkg.
module cbsm_xlate
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cbsm_pkg::cfg_t        cfg,
    input  logic                  step,
    input  cbsm_pkg::in_item_t    item,
    output cbsm_pkg::out_item_t   result
);

    logic       wire_latch_reg;
    logic       wire_latch_next;
    logic [4:0] prg_low_reg;
    logic [4:0] prg_low_next;
    logic [4:0] prg_mid_reg;
    logic [4:0] prg_mid_next;
    logic       mirror_reg;
    logic       mirror_next;
    logic [7:0] chr_bank_reg [8];
    logic [7:0] chr_win_reg  [8];
    logic [7:0] chr_nib_next;
    logic [7:0] chr_win_next;
    logic       chr_wr;

    logic [3:0] top;
    logic [3:0] pair;
    logic [2:0] chr_slot;
    logic [5:0] prg_mask;
    logic [8:0] chr_mask;
    logic [4:0] prg_bank;
    logic [7:0] chr_cur;

    // Address decode of CPU writes (mask F003 keeps the top nibble and bits 1:0).
    assign top      = item.address[15:12];
    assign pair     = top - cbsm_pkg::REGION_CHR_FIRST;
    assign chr_slot = {pair[1:0], item.address[1]};
    assign prg_mask = cfg.prg_banks - 6'd1;
    assign chr_mask = cfg.chr_banks - 9'd1;
    assign chr_cur  = chr_bank_reg[chr_slot];

    // Next bank state for a CPU write.
    always_comb
    begin
        wire_latch_next = wire_latch_reg;
        prg_low_next    = prg_low_reg;
        prg_mid_next    = prg_mid_reg;
        mirror_next     = mirror_reg;
        chr_wr          = 1'b0;
        chr_nib_next    = chr_cur;
        if (item.op == cbsm_pkg::OP_CPU_WRITE)
        begin
            if (top == cbsm_pkg::REGION_LATCH)
            begin
                wire_latch_next = item.data[0];
            end
            else if (top == cbsm_pkg::REGION_PRG_LO)
            begin
                prg_low_next = item.data[4:0] & prg_mask[4:0];
            end
            else if (top == cbsm_pkg::REGION_PRG_MID)
            begin
                prg_mid_next = item.data[4:0] & prg_mask[4:0];
            end
            else if (top == cbsm_pkg::REGION_MIRROR)
            begin
                mirror_next = item.data[1];
            end
            else if (top inside {[cbsm_pkg::REGION_CHR_FIRST:cbsm_pkg::REGION_CHR_LAST]})
            begin
                chr_wr = 1'b1;
                if (item.address[0])
                begin
                    chr_nib_next = {item.data[3:0], chr_cur[3:0]};
                end
                else
                begin
                    chr_nib_next = {chr_cur[7:4], item.data[3:0]};
                end
            end
        end
    end

    assign chr_win_next = chr_nib_next & chr_mask[7:0];

    // Bank state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wire_latch_reg <= 1'b0;
            prg_low_reg    <= 5'd0;
            prg_mid_reg    <= cbsm_pkg::PRG_MID_RST;
            mirror_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chr_bank_reg[i] <= 8'd0;
                chr_win_reg[i]  <= 8'(i);
            end
        end
        else if (step)
        begin
            wire_latch_reg <= wire_latch_next;
            prg_low_reg    <= prg_low_next;
            prg_mid_reg    <= prg_mid_next;
            mirror_reg     <= mirror_next;
            if (chr_wr)
            begin
                chr_bank_reg[chr_slot] <= chr_nib_next;
                chr_win_reg[chr_slot]  <= chr_win_next;
            end
        end
    end

    // Program bank for the 8K window that a CPU read falls in.
    always_comb
    begin
        case (item.address[14:13])
            2'd0:    prg_bank = prg_low_reg;
            2'd1:    prg_bank = prg_mid_reg;
            2'd2:    prg_bank = cfg.prg_banks[4:0] - 5'd2;
            default: prg_bank = cfg.prg_banks[4:0] - 5'd1;
        endcase
    end

    // Result of the access; mirroring reflects this item's own update.
    always_comb
    begin
        result.kind              = cbsm_pkg::KIND_NONE;
        result.mem_address       = 18'd0;
        result.read_data         = 8'd0;
        result.mirror_horizontal = mirror_next;
        case (item.op)
            cbsm_pkg::OP_CPU_READ:
            begin
                if (top == cbsm_pkg::REGION_LATCH)
                begin
                    result.kind      = cbsm_pkg::KIND_DATA;
                    result.read_data = cbsm_pkg::LATCH_READ_BASE | {7'd0, wire_latch_reg};
                end
                else if (top == cbsm_pkg::REGION_ID)
                begin
                    result.kind      = cbsm_pkg::KIND_DATA;
                    result.read_data = cbsm_pkg::ID_READ_VALUE;
                end
                else if (item.address[15])
                begin
                    result.kind        = cbsm_pkg::KIND_PRG;
                    result.mem_address = {prg_bank, item.address[12:0]};
                end
            end
            cbsm_pkg::OP_PPU_READ, cbsm_pkg::OP_PPU_WRITE:
            begin
                if (item.address[15:13] == 3'd0)
                begin
                    result.kind        = cbsm_pkg::KIND_CHR;
                    result.mem_address = {chr_win_reg[item.address[12:10]],
                                          item.address[9:0]};
                end
            end
            default:
            begin
                result.kind = cbsm_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

@@ hdl/cartridge_bank_switch_mapper.sv @@
// Top level of the cartridge bank switch mapper: input and result registers.
// Instantiates cbsm_cfg and cbsm_xlate; depends on cbsm_pkg.
//
//   Channel   Direction  Handshake                 Payload
//   in        to block   in_valid / in_stall       in_item  (op, address, data)
//   out       from block out_valid / out_stall     out_item (kind, mem_address,
//                                                  read_data, mirror_horizontal)
//   config    to block   psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; each item passes from
// acceptance into the input register, then through the decode into the result register.
// Bank state changes when an item leaves the input register.
// Reset clears the valid bits of both registers, sizes go to 32 and 256 program and character banks,
// the middle program window to bank 29 and character window i to bank i.
// A stalled result holds the input register, which then stalls the input channel.
module cartridge_bank_switch_mapper
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cbsm_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cbsm_pkg::out_item_t                 out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbsm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cbsm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [cbsm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    cbsm_pkg::cfg_t      cfg;
    cbsm_pkg::in_item_t  in_item_reg;
    cbsm_pkg::out_item_t out_item_reg;
    cbsm_pkg::out_item_t result;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic                advance;
    logic                in_load;

    // Flow control between the two registers.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_load  = in_valid && !in_stall;

    cbsm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbsm_xlate u_xlate
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_load || advance)
        begin
            in_vld_reg <= in_load;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_item;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance || !out_stall)
        begin
            out_vld_reg <= advance;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    // A CPU write never produces a result value.
    a_write_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.op == cbsm_pkg::OP_CPU_WRITE
        |=> out_item.kind == cbsm_pkg::KIND_NONE)
        else $error("CPU write produced a non-empty result");

    // A PPU access below 2000 always gives a character address.
    a_ppu_gives_chr: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.op[1] && in_item_reg.address[15:13] == 3'd0
        |=> out_valid && out_item.kind == cbsm_pkg::KIND_CHR)
        else $error("PPU access in pattern space did not give a character address");

    // A held item in the input register is never dropped.
    a_input_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg)
        else $error("Item lost from the input register");

endmodule
